FILE: design/apq_pkg.sv
`default_nettype none

package apq_pkg;

    localparam int COMP_W  = 8;
    localparam int IDX_W   = 8;
    localparam int C565_W  = 16;
    localparam int SUM_W   = 10;
    localparam int DIST_W  = 9;

    // floor(x/3) = (x*683) >> 11 for x below 1024
    localparam int DIV3_MUL = 683;
    localparam int DIV3_SH  = 11;
    localparam int PROD_W   = 20;

    localparam logic [DIST_W-1:0] DIST_INIT = DIST_W'(256);

    typedef struct packed {
        logic load;
        logic conv;
        logic rescan;
        logic match_step;
        logic near_step;
        logic append;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic found;
        logic full;
        logic out_free;
    } t_sts;

    // floor(x/255) for x below 16320
    function automatic logic [5:0] div255(input logic [13:0] x);
        logic [14:0] t;
        t = 15'(x) + 15'(x >> 8) + 15'd1;
        return t[13:8];
    endfunction

endpackage

`default_nettype wire

FILE: design/apq_if.sv
`default_nettype none

interface apq_pix_if;
    import apq_pkg::*;

    logic              valid;
    logic              ready;
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
    logic              first_of_image;

    modport source (output valid, red, green, blue, first_of_image, input ready);
    modport sink   (input valid, red, green, blue, first_of_image, output ready);
endinterface

interface apq_res_if;
    import apq_pkg::*;

    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  color_index;
    logic              added_new;
    logic              approximated;
    logic [C565_W-1:0] color565;

    modport source (output valid, color_index, added_new, approximated, color565,
                    input ready);
    modport sink   (input valid, color_index, added_new, approximated, color565,
                    output ready);
endinterface

`default_nettype wire

FILE: design/apq_ctrl.sv
`default_nettype none

module apq_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  apq_pkg::t_sts      i_sts,
    output apq_pkg::t_cmd      o_cmd
);
    import apq_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CONV   = 6'b000010,
        S_MATCH  = 6'b000100,
        S_NEAR   = 6'b001000,
        S_APPEND = 6'b010000,
        S_EMIT   = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                o_cmd.conv = 1'b1;
                n_state    = S_MATCH;
            end
            S_MATCH: begin
                o_cmd.match_step = 1'b1;
                if (i_sts.scan_done) begin
                    if (i_sts.found) begin
                        n_state = S_EMIT;
                    end else if (i_sts.full) begin
                        o_cmd.rescan = 1'b1;
                        n_state      = S_NEAR;
                    end else begin
                        n_state = S_APPEND;
                    end
                end
            end
            S_NEAR: begin
                o_cmd.near_step = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_EMIT;
                end
            end
            S_APPEND: begin
                o_cmd.append = 1'b1;
                n_state      = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: design/apq_dp.sv
`default_nettype none

module apq_dp #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  apq_pkg::t_cmd                     i_cmd,
    output apq_pkg::t_sts                     o_sts,
    input  wire logic [apq_pkg::COMP_W-1:0]   i_red,
    input  wire logic [apq_pkg::COMP_W-1:0]   i_green,
    input  wire logic [apq_pkg::COMP_W-1:0]   i_blue,
    input  wire logic                         i_first_of_image,
    input  wire logic                         i_out_ready,
    output logic                              o_out_valid,
    output logic [apq_pkg::IDX_W-1:0]         o_color_index,
    output logic                              o_added_new,
    output logic                              o_approximated,
    output logic [apq_pkg::C565_W-1:0]        o_color565
);
    import apq_pkg::*;

    localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int CW = $clog2(PALETTE_ENTRIES + 1);
    localparam logic [CW-1:0] CAP = CW'(PALETTE_ENTRIES);

    logic [C565_W-1:0] r_mem [PALETTE_ENTRIES];

    logic [COMP_W-1:0] r_red;
    logic [COMP_W-1:0] r_green;
    logic [COMP_W-1:0] r_blue;
    logic [C565_W-1:0] r_c565;
    logic [CW-1:0]     r_filled;
    logic [CW-1:0]     r_rd_cnt;
    logic              r_pend;
    logic [AW-1:0]     r_pend_idx;
    logic [C565_W-1:0] r_rd_data;
    logic              r_found;
    logic [SUM_W-1:0]  r_sum;
    logic              r_sum_vld;
    logic [AW-1:0]     r_sum_idx;
    logic [DIST_W-1:0] r_best;
    logic [AW-1:0]     r_idx;
    logic              r_added;
    logic              r_approx;

    logic              more;
    logic              issue;
    logic [4:0]        r5;
    logic [5:0]        g6;
    logic [4:0]        b5;
    logic [4:0]        dr;
    logic [5:0]        dg;
    logic [4:0]        db;
    logic [SUM_W-1:0]  sum;
    logic [PROD_W-1:0] prod;
    logic [DIST_W-1:0] cur_dist;

    assign more  = (r_rd_cnt < r_filled);
    assign issue = (i_cmd.match_step || i_cmd.near_step) && more && !r_found;

    // rgb888 to rgb565
    assign r5 = 5'(div255(14'(r_red) * 14'd31));
    assign g6 = div255(14'(r_green) * 14'd63);
    assign b5 = 5'(div255(14'(r_blue) * 14'd31));

    // expanded l1 distance
    always_comb begin
        dr = (r_c565[15:11] > r_rd_data[15:11]) ? r_c565[15:11] - r_rd_data[15:11]
                                                : r_rd_data[15:11] - r_c565[15:11];
        dg = (r_c565[10:5] > r_rd_data[10:5]) ? r_c565[10:5] - r_rd_data[10:5]
                                              : r_rd_data[10:5] - r_c565[10:5];
        db = (r_c565[4:0] > r_rd_data[4:0]) ? r_c565[4:0] - r_rd_data[4:0]
                                            : r_rd_data[4:0] - r_c565[4:0];
        sum = SUM_W'({dr, 3'b000}) + SUM_W'({dg, 2'b00}) + SUM_W'({db, 3'b000});
    end

    assign prod     = PROD_W'(r_sum) * PROD_W'(DIV3_MUL);
    assign cur_dist = DIST_W'(prod >> DIV3_SH);

    always_comb begin
        o_sts.scan_done = r_found || (!more && !r_pend && !r_sum_vld);
        o_sts.found     = r_found;
        o_sts.full      = (r_filled == CAP);
        o_sts.out_free  = !o_out_valid || i_out_ready;
    end

    // palette memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.append) begin
            r_mem[r_filled[AW-1:0]] <= r_c565;
        end
        if (issue) begin
            r_rd_data <= r_mem[r_rd_cnt[AW-1:0]];
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_red   <= i_red;
            r_green <= i_green;
            r_blue  <= i_blue;
        end
        if (i_cmd.conv) begin
            r_c565 <= {r5, g6, b5};
        end
        r_pend_idx <= r_rd_cnt[AW-1:0];
        r_sum_idx  <= r_pend_idx;
        r_sum      <= sum;
        if (i_cmd.emit) begin
            o_color_index  <= IDX_W'(r_idx);
            o_added_new    <= r_added;
            o_approximated <= r_approx;
            o_color565     <= r_c565;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled    <= '0;
            r_rd_cnt    <= '0;
            r_pend      <= 1'b0;
            r_found     <= 1'b0;
            r_sum_vld   <= 1'b0;
            r_best      <= DIST_INIT;
            r_idx       <= '0;
            r_added     <= 1'b0;
            r_approx    <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load && i_first_of_image) begin
                r_filled <= '0;
            end

            if (i_cmd.conv || i_cmd.rescan) begin
                r_rd_cnt  <= '0;
                r_pend    <= 1'b0;
                r_found   <= 1'b0;
                r_sum_vld <= 1'b0;
                r_best    <= DIST_INIT;
                r_idx     <= '0;
                r_approx  <= i_cmd.rescan;
                if (i_cmd.conv) begin
                    r_added <= 1'b0;
                end
            end else begin
                if (issue) begin
                    r_rd_cnt <= r_rd_cnt + CW'(1);
                end
                r_pend    <= issue;
                r_sum_vld <= i_cmd.near_step && r_pend;

                if (i_cmd.match_step && r_pend && !r_found && (r_rd_data == r_c565)) begin
                    r_found <= 1'b1;
                    r_idx   <= r_pend_idx;
                end

                if (i_cmd.near_step && r_sum_vld && (cur_dist < r_best)) begin
                    r_best <= cur_dist;
                    r_idx  <= r_sum_idx;
                end

                if (i_cmd.append) begin
                    r_idx    <= r_filled[AW-1:0];
                    r_filled <= r_filled + CW'(1);
                    r_added  <= 1'b1;
                end
            end

            if (i_cmd.emit) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/adaptive_palette_quantizer_unit.sv
`default_nettype none

// adaptive palette quantizer
// i_pix carries one rgb888 pixel per item plus a first_of_image flag that
// empties the palette before the pixel is handled. o_res carries one item per
// pixel: the palette index, whether the color was appended, whether the
// nearest entry was used because the palette was full, and the rgb565 value.
// One pixel is worked on at a time: an exact-match scan of the filled entries
// ends at a hit, else the pixel is appended while there is room, or a
// nearest-color scan over all entries picks the index when the palette is full.
// The palette memory is read one entry per cycle, first for the exact-match
// scan and, when the palette is full, again for the nearest-color scan;
// that memory port sets the throughput.
// A finished result waits in the output register, so the next pixel is
// accepted while o_res is stalled; the block then holds in its last step
// until the register frees.
// Reset empties the palette and drops any pending result.
module adaptive_palette_quantizer_unit #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    apq_pix_if.sink     i_pix,
    apq_res_if.source   o_res
);
    import apq_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic in_ready;

    assign i_pix.ready = in_ready;

    apq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pix.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    apq_dp #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_red            (i_pix.red),
        .i_green          (i_pix.green),
        .i_blue           (i_pix.blue),
        .i_first_of_image (i_pix.first_of_image),
        .i_out_ready      (o_res.ready),
        .o_out_valid      (o_res.valid),
        .o_color_index    (o_res.color_index),
        .o_added_new      (o_res.added_new),
        .o_approximated   (o_res.approximated),
        .o_color565       (o_res.color565)
    );

endmodule

`default_nettype wire
